// File: rtl/core/mpmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpmp_pkg
// Shared types and constants of the min-plus matrix power core.
// ----------------------------------------------------------------------------
package mpmp_pkg;

  localparam int          DW        = 31;            // stored distance width
  localparam logic [30:0] INF_DIST  = 31'h7FFF_FFFF; // no path
  localparam int          CFG_AW    = 3;             // APB byte address width
  localparam logic [4:0]  VC_RESET  = 5'd16;

  // request opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // register index
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] weight;
  } in_t;

  typedef struct packed {
    logic signed [31:0] distance;
    logic               run_done;
  } out_t;

  // control of the min-plus accumulator
  typedef struct packed {
    logic vld;
    logic first;
  } acc_ctl_t;

endpackage : mpmp_pkg
`default_nettype wire

// File: rtl/core/mpmp_term_acc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpmp_term_acc
// Saturating min-plus term and running minimum over k.
// ----------------------------------------------------------------------------
module mpmp_term_acc (
  input  wire                    clk,
  input  wire mpmp_pkg::acc_ctl_t ctl,
  input  wire  [30:0]            op_a,
  input  wire  [30:0]            op_b,
  output logic [30:0]            best_nxt
);
  import mpmp_pkg::*;

  logic [31:0] sum;
  logic [30:0] term;
  logic [30:0] acc_r;

  always_comb begin
    sum = {1'b0, op_a} + {1'b0, op_b};
    if (op_a == INF_DIST || op_b == INF_DIST || sum >= {1'b0, INF_DIST}) begin
      term = INF_DIST;
    end else begin
      term = sum[30:0];
    end
    if (ctl.first || term < acc_r) begin
      best_nxt = term;
    end else begin
      best_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      acc_r <= best_nxt;
    end
  end

endmodule : mpmp_term_acc
`default_nettype wire

// File: rtl/core/min_plus_matrix_power_shortest_paths_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// min_plus_matrix_power_shortest_paths_core
// All-pairs shortest paths by min-plus matrix power (square-and-multiply).
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, busy, in_req            taken when start & !busy
//  result    out_valid, out_data            one-cycle strobe, no back-pressure
//  config    psel..pready                   APB write, pready tied high
//
//  A read answers on the cycle after it is taken. A run holds busy high
//  through an init sweep and M min-plus matrix products, each a multiply
//  sweep and a copy sweep, with n the active vertex count and M at most
//  2*log2(n)+1; each multiply sweep makes one read/modify pass over the
//  scratch memories per k step.
//  The run answer strobes in the first cycle after busy drops.
//  Reset clears control only; matrix memories hold junk until written.
//  The result side cannot stall.
// ----------------------------------------------------------------------------
module min_plus_matrix_power_shortest_paths_core #(
  parameter int MAX_VERTICES = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // request channel
  input  wire                            start,
  output logic                           busy,
  input  wire mpmp_pkg::in_t             in_req,
  // result channel
  output logic                           out_valid,
  output mpmp_pkg::out_t                 out_data,
  // APB configuration
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [mpmp_pkg::CFG_AW-1:0]    paddr,
  input  wire  [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import mpmp_pkg::*;

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CELLS = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(CELLS);
  localparam int NCAP  = (MAX_VERTICES < 31) ? MAX_VERTICES : 31;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_STEP} state_t;
  typedef enum logic [1:0] {PH_INIT, PH_MUL, PH_COPY} phase_t;

  function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                              input logic [IDX_W-1:0] c);
    cell_addr = AW'(int'(r) * MAX_VERTICES + int'(c));
  endfunction

  // --- configuration ---------------------------------------------------------
  logic [4:0] vc_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= VC_RESET;
    end else if (cfg_wr && paddr[2] == REG_VERTEX_COUNT) begin
      vc_r <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {27'd0, vc_r} : 32'd0;

  // active size: 0 acts as 1, clamp to the array size
  logic [4:0] n;
  always_comb begin
    if (vc_r == 5'd0) begin
      n = 5'd1;
    end else if (int'(vc_r) > MAX_VERTICES) begin
      n = 5'(NCAP);
    end else begin
      n = vc_r;
    end
  end

  // --- sequencer -------------------------------------------------------------
  state_t            state_r;
  phase_t            ph_r;
  logic [IDX_W-1:0]  i_r, j_r, k_r;
  logic [8:0]        exp_r;
  logic              odd_done_r;
  logic              sq_r;          // 1: scratch = scratch^2, 0: result *= scratch
  logic              p1_vld_r;
  phase_t            p1_ph_r;
  logic              p1_first_r, p1_last_r, p1_diag_r;
  logic [AW-1:0]     p1_wa_r;
  logic              out_valid_r, out_run_r;
  logic              rd_oor_r, rd_diag_r;

  logic i_last, j_last, k_last, acc_req;
  assign i_last  = int'(i_r) == int'(n) - 1;
  assign j_last  = int'(j_r) == int'(n) - 1;
  assign k_last  = int'(k_r) == int'(n) - 1;
  assign acc_req = start && !busy;
  assign busy    = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= PH_INIT;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      exp_r       <= 9'd0;
      odd_done_r  <= 1'b0;
      sq_r        <= 1'b0;
      p1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_run_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_run_r   <= 1'b0;
      p1_vld_r    <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc_req && in_req.opcode == OP_RUN) begin
            state_r    <= S_ISSUE;
            ph_r       <= PH_INIT;
            i_r        <= '0;
            j_r        <= '0;
            k_r        <= '0;
            exp_r      <= 9'(n);
            odd_done_r <= 1'b0;
          end else if (acc_req && in_req.opcode == OP_READ) begin
            out_valid_r <= 1'b1;
          end
        end
        S_ISSUE: begin
          p1_vld_r   <= 1'b1;
          p1_ph_r    <= ph_r;
          p1_first_r <= k_r == '0;
          p1_last_r  <= ph_r != PH_MUL || k_last;
          p1_wa_r    <= cell_addr(i_r, j_r);
          p1_diag_r  <= i_r == j_r;
          if (ph_r == PH_MUL && !k_last) begin
            k_r <= k_r + 1'b1;
          end else begin
            k_r <= '0;
            if (!j_last) begin
              j_r <= j_r + 1'b1;
            end else begin
              j_r <= '0;
              if (!i_last) begin
                i_r <= i_r + 1'b1;
              end else begin
                i_r     <= '0;
                state_r <= S_WAIT;
              end
            end
          end
        end
        S_WAIT: begin
          // last write of the sweep lands at this edge
          if (ph_r == PH_MUL) begin
            ph_r    <= PH_COPY;
            state_r <= S_ISSUE;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          if (exp_r == 9'd0) begin
            out_valid_r <= 1'b1;
            out_run_r   <= 1'b1;
            state_r     <= S_IDLE;
          end else if (exp_r[0] && !odd_done_r) begin
            odd_done_r <= 1'b1;
            sq_r       <= 1'b0;
            ph_r       <= PH_MUL;
            state_r    <= S_ISSUE;
          end else begin
            odd_done_r <= 1'b0;
            exp_r      <= exp_r >> 1;
            if ((exp_r >> 1) == 9'd0) begin
              out_valid_r <= 1'b1;
              out_run_r   <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              sq_r    <= 1'b1;
              ph_r    <= PH_MUL;
              state_r <= S_ISSUE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // read-request flags (payload)
  always_ff @(posedge clk) begin
    if (acc_req) begin
      rd_oor_r  <= !({1'b0, in_req.row} < n && {1'b0, in_req.col} < n);
      rd_diag_r <= in_req.row == in_req.col;
    end
  end

  // --- memories --------------------------------------------------------------
  logic [DW-1:0] base_mem [CELLS];
  logic [DW-1:0] res_mem  [CELLS];
  logic [DW-1:0] scr_mem  [CELLS];
  logic [DW-1:0] prod_mem [CELLS];
  logic [DW-1:0] base_rd_r, res_rd_r, scr_rd0_r, scr_rd1_r, prod_rd_r;

  logic          base_we, res_we, scr_we, prod_we;
  logic [AW-1:0] base_wa, res_ra;
  logic [DW-1:0] base_wd, res_wd, scr_wd, best_nxt;
  logic          p1_mul, p1_copy, p1_init;

  assign base_we = acc_req && in_req.opcode == OP_WRITE
                   && int'(in_req.row) < MAX_VERTICES && int'(in_req.col) < MAX_VERTICES;
  assign base_wa = cell_addr(IDX_W'(in_req.row), IDX_W'(in_req.col));
  // zero weight off the diagonal means no edge
  assign base_wd = (in_req.weight == 16'd0 && in_req.row != in_req.col)
                   ? INF_DIST : {15'd0, in_req.weight};

  assign res_ra  = busy ? cell_addr(i_r, k_r)
                        : cell_addr(IDX_W'(in_req.row), IDX_W'(in_req.col));

  assign p1_init = p1_vld_r && p1_ph_r == PH_INIT;
  assign p1_mul  = p1_vld_r && p1_ph_r == PH_MUL;
  assign p1_copy = p1_vld_r && p1_ph_r == PH_COPY;

  assign res_we  = p1_init || (p1_copy && !sq_r);
  assign res_wd  = p1_init ? (p1_diag_r ? '0 : INF_DIST) : prod_rd_r;
  assign scr_we  = p1_init || (p1_copy && sq_r);
  assign scr_wd  = p1_init ? base_rd_r : prod_rd_r;
  assign prod_we = p1_mul && p1_last_r;

  always_ff @(posedge clk) begin
    if (base_we) begin
      base_mem[base_wa] <= base_wd;
    end
    base_rd_r <= base_mem[cell_addr(i_r, j_r)];
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[p1_wa_r] <= res_wd;
    end
    res_rd_r <= res_mem[res_ra];
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[p1_wa_r] <= scr_wd;
    end
    scr_rd0_r <= scr_mem[cell_addr(i_r, k_r)];
    scr_rd1_r <= scr_mem[cell_addr(k_r, j_r)];
  end

  always_ff @(posedge clk) begin
    if (prod_we) begin
      prod_mem[p1_wa_r] <= best_nxt;
    end
    prod_rd_r <= prod_mem[cell_addr(i_r, j_r)];
  end

  // --- min-plus accumulate ---------------------------------------------------
  acc_ctl_t acc_ctl;
  assign acc_ctl = '{vld: p1_mul, first: p1_first_r};

  mpmp_term_acc u_acc (
    .clk      (clk),
    .ctl      (acc_ctl),
    .op_a     (sq_r ? scr_rd0_r : res_rd_r),
    .op_b     (scr_rd1_r),
    .best_nxt (best_nxt)
  );

  // --- result ----------------------------------------------------------------
  assign out_valid = out_valid_r;
  always_comb begin
    out_data.run_done = out_run_r;
    if (out_run_r) begin
      out_data.distance = 32'sd0;
    end else if (rd_oor_r || (res_rd_r == INF_DIST && !rd_diag_r)) begin
      out_data.distance = -32'sd1;
    end else begin
      out_data.distance = signed'({1'b0, res_rd_r});
    end
  end

  // --- assertions ------------------------------------------------------------
  a_idle_exp_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> exp_r == 9'd0)
    else $error("exponent not cleared at idle");

  a_run_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc_req && in_req.opcode == OP_RUN |=> busy)
    else $error("run request did not start");

  a_run_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.run_done |-> $past(busy))
    else $error("run answer without a run");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && $past(!busy) |-> !p1_vld_r)
    else $error("sweep write outside a run");

endmodule : min_plus_matrix_power_shortest_paths_core
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the min-plus matrix power core. The weight matrix
// is filled first. After that the bench sends directed requests, then random
// writes, runs, reads and unused opcodes under several vertex counts. It
// predicts each answer from its own copy of the matrices and checks every result strobe against that prediction.
// ----------------------------------------------------------------------------
module tb;
  import mpmp_pkg::*;

  localparam int          NMAX    = 16;
  localparam int          CELLS   = NMAX * NMAX;
  localparam logic [1:0]  OP_NONE = 2'd3;      // unused opcode, no answer
  localparam int          LIMIT   = 3000000;
  localparam logic [31:0] INF32   = 32'h7FFF_FFFF;

  typedef logic [30:0] dist_mat_t [CELLS];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_req = '0;
  logic        out_valid;
  out_t        out_data;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  min_plus_matrix_power_shortest_paths_core #(.MAX_VERTICES(NMAX)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // request source and answer store
  in_t  req_pending_q[$];
  out_t answer_expect_q[$];
  int   errors = 0;
  int   idle_pct = 0;
  logic taken = 1'b0;

  // predictor state
  logic [4:0] vc_reg = VC_RESET;
  dist_mat_t  base_m, path_m, sq_m;

  function automatic int active_n(logic [4:0] vc);
    if (vc == 0) return 1;
    if (vc > NMAX) return NMAX;
    return vc;
  endfunction

  // x (min-plus) y over the active block; cells outside keep x
  function automatic dist_mat_t minplus(dist_mat_t x, dist_mat_t y, int n);
    dist_mat_t   d;
    logic [31:0] best, t;
    logic [32:0] s;
    d = x;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        best = INF32;
        for (int k = 0; k < n; k++) begin
          s = {2'b0, x[i*NMAX+k]} + {2'b0, y[k*NMAX+j]};
          if (x[i*NMAX+k] == INF_DIST || y[k*NMAX+j] == INF_DIST || s >= INF32)
            t = INF32;
          else
            t = s[31:0];
          if (t < best) best = t;
        end
        d[i*NMAX+j] = best[30:0];
      end
    return d;
  endfunction

  task automatic apply_request(in_t r);
    int          n;
    logic [8:0]  e;
    logic [30:0] v;
    out_t        ans;
    n = active_n(vc_reg);
    case (r.opcode)
      OP_WRITE: begin
        base_m[r.row*NMAX+r.col] = (r.weight == 0 && r.row != r.col) ?
                                   INF_DIST : {15'd0, r.weight};
      end
      OP_RUN: begin
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) begin
            path_m[i*NMAX+j] = (i == j) ? '0 : INF_DIST;
            sq_m[i*NMAX+j]   = base_m[i*NMAX+j];
          end
        e = 9'(n);
        while (e != 0) begin
          if (e[0]) path_m = minplus(path_m, sq_m, n);
          e = e >> 1;
          if (e != 0) sq_m = minplus(sq_m, sq_m, n);
        end
        ans.distance = 0;
        ans.run_done = 1'b1;
        answer_expect_q.push_back(ans);
      end
      OP_READ: begin
        ans.run_done = 1'b0;
        if (r.row >= n || r.col >= n) begin
          ans.distance = -1;
        end else begin
          v = path_m[r.row*NMAX+r.col];
          ans.distance = (v == INF_DIST && r.row != r.col) ? -1 : {1'b0, v};
        end
        answer_expect_q.push_back(ans);
      end
      default: ;
    endcase
  endtask

  // monitor: check the strobe first, then predict the request taken here
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      taken <= start && !busy;
      if (out_valid) begin
        if (answer_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        end else begin
          want = answer_expect_q.pop_front();
          if (out_data.distance !== want.distance || out_data.run_done !== want.run_done) begin
            errors++;
            $display("%0t: mismatch, expected dist=%0d done=%0b, actual dist=%0d done=%0b",
                     $time, want.distance, want.run_done, out_data.distance,
                     out_data.run_done);
          end
        end
      end
      if (start && !busy) apply_request(in_req);
    end
  end

  // driver: present the next request once the previous one is taken
  always @(negedge clk) begin
    if (rst_n && (!start || taken)) begin
      if (req_pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_req <= req_pending_q.pop_front();
        start  <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // generator-side record of which result cells a run has written
  bit   path_known [CELLS];
  logic [4:0] gen_vc = VC_RESET;

  function automatic in_t mk(logic [1:0] op, int r, int c, int w);
    in_t x;
    x.opcode = op;
    x.row    = 4'(r);
    x.col    = 4'(c);
    x.weight = 16'(w);
    return x;
  endfunction

  function automatic int rand_weight();
    case ($urandom_range(9))
      0, 1, 2: return 0;
      3:       return 16'hFFFF;
      4:       return $urandom_range(65535);
      default: return $urandom_range(1, 30);
    endcase
  endfunction

  task automatic push_req(in_t x);
    int n;
    n = active_n(gen_vc);
    if (x.opcode == OP_RUN)
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) path_known[i*NMAX+j] = 1'b1;
    req_pending_q.push_back(x);
  endtask

  // wait for the core to drain, then write vertex_count over APB
  task automatic set_vertex_count(logic [4:0] vc);
    wait (req_pending_q.size() == 0 && !start && answer_expect_q.size() == 0);
    repeat (10) @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= CFG_AW'({REG_VERTEX_COUNT, 2'b00}); pwdata <= {27'd0, vc};
    @(negedge clk) penable <= 1'b1;
    @(negedge clk) begin
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    end
    vc_reg = vc;
    gen_vc = vc;
  endtask

  logic [4:0] vc_plan [11] = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd3, 5'd5,
                               5'd31, 5'd4, 5'd7, 5'd2, 5'd6};

  initial begin
    int   n, r, c, pick;
    in_t  x;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // fill the whole matrix so no run sees an undefined weight
    for (int i = 0; i < NMAX; i++)
      for (int j = 0; j < NMAX; j++)
        push_req(mk(OP_WRITE, i, j, (i == j) ? 0 : $urandom_range(1, 40)));

    // directed: no-edge column, extreme weights, unused opcode
    for (int i = 0; i < NMAX - 1; i++) push_req(mk(OP_WRITE, i, 15, 0));
    push_req(mk(OP_WRITE, 0, 1, 16'hFFFF));
    push_req(mk(OP_WRITE, 1, 2, 1));
    push_req(mk(OP_WRITE, 3, 3, 7));       // nonzero diagonal
    push_req(mk(OP_NONE, 15, 15, 16'hFFFF));
    push_req(mk(OP_RUN, 0, 0, 0));
    push_req(mk(OP_READ, 0, 0, 0));
    push_req(mk(OP_READ, 0, 15, 0));       // unreachable pair
    push_req(mk(OP_READ, 15, 0, 0));
    push_req(mk(OP_READ, 15, 15, 0));
    push_req(mk(OP_READ, 3, 3, 0));
    push_req(mk(OP_READ, 0, 2, 0));

    // random phases, each under its own vertex count
    for (int p = 0; p < 11; p++) begin
      set_vertex_count(vc_plan[p]);        // sender pauses until drained
      idle_pct = (p < 4) ? 11 : (p < 8) ? 70 : 0;
      n = active_n(gen_vc);
      push_req(mk(OP_RUN, 0, 0, 0));
      for (int k = 0; k < 142; k++) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          push_req(mk(OP_WRITE, $urandom_range(15), $urandom_range(15), rand_weight()));
        end else if (pick < 48 || (n < 12 && pick < 52)) begin
          push_req(mk(OP_RUN, $urandom_range(15), $urandom_range(15), $urandom));
        end else if (pick < 50 && n >= 12) begin
          push_req(mk(OP_NONE, $urandom_range(15), $urandom_range(15), $urandom));
        end else if (pick < 54) begin
          push_req(mk(OP_NONE, $urandom_range(15), $urandom_range(15), $urandom));
        end else begin
          if ($urandom_range(9) < 8) begin
            r = $urandom_range(n - 1);
            c = $urandom_range(n - 1);
          end else begin
            r = $urandom_range(15);
            c = $urandom_range(15);
          end
          x = mk(OP_READ, r, c, $urandom);
          if (r < n && c < n && !path_known[r*NMAX+c]) x.opcode = OP_RUN;
          push_req(x);
        end
      end
    end

    wait (req_pending_q.size() == 0 && !start && answer_expect_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: min_plus_matrix_power_shortest_paths_core.f
rtl/core/mpmp_pkg.sv
rtl/core/mpmp_term_acc.sv
rtl/core/min_plus_matrix_power_shortest_paths_core.sv
tb/tb.sv
